// ===== rtl/core/dfq_pkg.sv =====
// Shared types and codes for the duplicate-rejecting FIFO queue.
`default_nettype none

package dfq_pkg;

  localparam int unsigned ItemBits = 32;

  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [1:0]          action;
    logic [ItemBits-1:0] item_value;
    logic [3:0]          entry_position;
  } dfq_in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [ItemBits-1:0] read_value;
    logic [4:0]          entry_count;
  } dfq_out_t;

  typedef struct packed {
    logic probe;
    logic push;
    logic shift;
  } dfq_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/dfq_cell.sv =====
// One queue cell: holds an entry, its occupancy and its match flag.
`default_nettype none

module dfq_cell
  import dfq_pkg::*;
#(
  parameter int unsigned StoreBits = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dfq_cell_ctrl_t       ctrl_i,
  input  wire logic [StoreBits-1:0] data_i,
  input  wire logic                 left_occ_i,
  input  wire logic [StoreBits-1:0] right_value_i,
  input  wire logic                 right_occ_i,
  output logic      [StoreBits-1:0] value_o,
  output logic                      occ_o,
  output logic                      hit_o
);

  logic [StoreBits-1:0] value_q;
  logic                 occ_q;
  logic                 hit_q;
  logic                 take_push;

  assign take_push = ctrl_i.push && !occ_q && left_occ_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (ctrl_i.shift) begin
        occ_q <= right_occ_i;
      end else if (take_push) begin
        occ_q <= 1'b1;
      end
      if (ctrl_i.probe) begin
        hit_q <= occ_q && (value_q == data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      value_q <= right_value_i;
    end else if (take_push) begin
      value_q <= data_i;
    end
  end

  assign value_o = value_q;
  assign occ_o   = occ_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

// ===== rtl/core/dedup_fifo_queue.sv =====
// Top level of the FIFO queue that rejects duplicate values.
//
// Input channel: in_valid_i / in_stall_o carry one request (enqueue, dequeue
// or peek) per transaction. Output channel: out_valid_o / out_stall_i carry
// one result per request, in request order, with status, read value and the
// entry count after the request.
// An accepted request first enters the compare step in the cells, which compare
// the value against every held entry and register a match flag, then the update
// step, which waits until the output register is free, then decides, updates the
// cells and loads the output register. A new request is taken only once the last
// one has passed both the compare step and the update step in the cell row.
// Reset empties the queue and the output register; no clearing pass runs.
// While the receiver stalls, the result holds in the output register. One
// more request is taken and compared, and then waits in the update step
// until the output register frees.
`default_nettype none

module dedup_fifo_queue
  import dfq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dfq_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dfq_out_t      out_data_o
);

  localparam int unsigned SB     = (VALUE_BITS < ItemBits) ? VALUE_BITS : ItemBits;
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned PW     = (CW > 4) ? CW : 4;
  localparam int unsigned PeekN  = (DEPTH < 16) ? DEPTH : 16;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic                 state_q, state_d;
  logic [1:0]           act_q;
  logic [SB-1:0]        val_q;
  logic [3:0]           pos_q;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  dfq_out_t             out_data_q;

  logic                 in_accept;
  logic                 out_free;
  logic                 commit;
  logic                 dup;
  logic                 push_c, shift_c;
  logic [2:0]           status_c;
  logic [ItemBits-1:0]  rd_c;
  logic [SB-1:0]        peek_val;
  logic [SB-1:0]        cell_data;
  dfq_cell_ctrl_t       cell_ctrl;

  logic [DEPTH-1:0]     occ_vec;
  logic [DEPTH-1:0]     hit_vec;
  logic [SB-1:0]        cell_val [DEPTH];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_EVAL) && out_free;
  assign dup        = |hit_vec;

  assign cell_data       = (state_q == S_IDLE) ? in_data_i.item_value[SB-1:0] : val_q;
  assign cell_ctrl.probe = in_accept;
  assign cell_ctrl.push  = commit && push_c;
  assign cell_ctrl.shift = commit && shift_c;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic          left_occ;
    logic [SB-1:0] right_val;
    logic          right_occ;

    if (g == 0) begin : g_head
      assign left_occ = 1'b1;
    end else begin : g_body
      assign left_occ = occ_vec[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_val = '0;
      assign right_occ = 1'b0;
    end else begin : g_link
      assign right_val = cell_val[g+1];
      assign right_occ = occ_vec[g+1];
    end

    dfq_cell #(
      .StoreBits(SB)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .data_i       (cell_data),
      .left_occ_i   (left_occ),
      .right_value_i(right_val),
      .right_occ_i  (right_occ),
      .value_o      (cell_val[g]),
      .occ_o        (occ_vec[g]),
      .hit_o        (hit_vec[g])
    );
  end

  always_comb begin
    peek_val = '0;
    for (int k = 0; k < PeekN; k++) begin
      if (pos_q == 4'(k)) begin
        peek_val = cell_val[k];
      end
    end
  end

  always_comb begin
    status_c = ST_OK;
    rd_c     = '0;
    push_c   = 1'b0;
    shift_c  = 1'b0;
    count_d  = count_q;
    case (act_q)
      ACT_ENQ: begin
        if (dup) begin
          status_c = ST_DUP;
        end else if (count_q == CW'(DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          push_c  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      ACT_DEQ: begin
        if (count_q == '0) begin
          status_c = ST_EMPTY;
        end else begin
          shift_c = 1'b1;
          rd_c    = ItemBits'(cell_val[0]);
          count_d = count_q - CW'(1);
        end
      end
      ACT_PEEK: begin
        if (PW'(pos_q) < PW'(count_q)) begin
          rd_c = ItemBits'(peek_val);
        end else begin
          status_c = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      act_q <= in_data_i.action;
      val_q <= in_data_i.item_value[SB-1:0];
      pos_q <= in_data_i.entry_position;
    end
    if (commit) begin
      out_data_q.status      <= status_c;
      out_data_q.read_value  <= rd_c;
      out_data_q.entry_count <= 5'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_occ_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(count_q))
    else $error("cell occupancy disagrees with entry count");

  a_occ_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, occ_vec} + (DEPTH + 1)'(1)))
    else $error("occupied cells are not packed toward the head");

  a_accept_evals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_EVAL))
    else $error("accepted transaction did not enter evaluation");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_OK)) |-> (out_data_o.read_value == '0))
    else $error("nonzero read value on a failed transaction");

endmodule

`default_nettype wire
